FILE: sv/sins_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sins_pkg
// Shared types, codes and helper functions of the strapdown integrator.
// ----------------------------------------------------------------------------
package sins_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_GRAV   = 2'd0;
    localparam logic [1:0] CFG_VEL0_X = 2'd1;
    localparam logic [1:0] CFG_VEL0_Y = 2'd2;
    localparam logic [1:0] CFG_VEL0_Z = 2'd3;

    localparam logic [31:0] GRAV_RESET = 32'd642253;

    // operand A sources
    localparam logic [1:0] A_Q   = 2'd0;
    localparam logic [1:0] A_M   = 2'd1;
    localparam logic [1:0] A_LIN = 2'd2;
    localparam logic [1:0] A_VB  = 2'd3;

    // operand B sources
    localparam logic [2:0] B_Q    = 3'd0;
    localparam logic [2:0] B_NEGG = 3'd1;
    localparam logic [2:0] B_VEL  = 3'd2;
    localparam logic [2:0] B_POS  = 3'd3;
    localparam logic [2:0] B_VB   = 3'd4;
    localparam logic [2:0] B_PB   = 3'd5;
    localparam logic [2:0] B_DT   = 3'd6;

    // writeback modes
    localparam logic [2:0] WB_NONE = 3'd0;
    localparam logic [2:0] WB_QP   = 3'd1;
    localparam logic [2:0] WB_MAT  = 3'd2;
    localparam logic [2:0] WB_ROT  = 3'd3;
    localparam logic [2:0] WB_VINT = 3'd4;
    localparam logic [2:0] WB_PINT = 3'd5;

    // rotation destinations
    localparam logic [2:0] DST_GB  = 3'd0;
    localparam logic [2:0] DST_VB  = 3'd1;
    localparam logic [2:0] DST_PB  = 3'd2;
    localparam logic [2:0] DST_VEL = 3'd3;
    localparam logic [2:0] DST_POS = 3'd4;

    // quaternion component slots
    localparam logic [3:0] QW = 4'd0;
    localparam logic [3:0] QX = 4'd1;
    localparam logic [3:0] QY = 4'd2;
    localparam logic [3:0] QZ = 4'd3;

    localparam logic [5:0] LAST_STEP = 6'd56;

    typedef struct packed {
        logic [1:0] a_src;
        logic [3:0] a_idx;
        logic [2:0] b_src;
        logic [1:0] b_idx;
        logic [2:0] mode;
        logic [2:0] dst;
        logic [3:0] didx;
        logic       clr;
        logic       last;
    } uop_t;

    typedef struct packed {
        logic capture;
        logic restart;
        logic out_load;
        uop_t uop;
    } sins_cmd_t;

    function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
        logic signed [31:0] r;
        if (v > 65'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -65'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [31:0] clamp_entry(input logic signed [35:0] v);
        logic signed [31:0] r;
        if (v > 36'sd1073741824)
            r = 32'sd1073741824;
        else if (v < -36'sd1073741824)
            r = -32'sd1073741824;
        else
            r = v[31:0];
        return r;
    endfunction

    // 1 - 2*(p + q)
    function automatic logic signed [31:0] mat_diag(input logic signed [31:0] p,
                                                    input logic signed [31:0] q);
        logic signed [35:0] s;
        s = 36'(p) + 36'(q);
        return clamp_entry(36'sd268435456 - (s <<< 1));
    endfunction

    // 2*(p + q) or 2*(p - q)
    function automatic logic signed [31:0] mat_off(input logic signed [31:0] p,
                                                   input logic signed [31:0] q,
                                                   input logic neg);
        logic signed [35:0] s;
        s = neg ? (36'(p) - 36'(q)) : (36'(p) + 36'(q));
        return clamp_entry(s <<< 1);
    endfunction

    // one multiply of a 3x3 rotation; o runs row-major over (i, j)
    function automatic uop_t rot_uop(input logic [3:0] o, input logic body,
                                     input logic [2:0] bsrc, input logic [2:0] dst);
        uop_t       u;
        logic [1:0] i;
        logic [3:0] jj;
        logic [1:0] j;
        u = '0;
        i = (o >= 4'd6) ? 2'd2 : ((o >= 4'd3) ? 2'd1 : 2'd0);
        jj = o - ({2'b00, i} * 4'd3);
        j = jj[1:0];
        u.a_src = A_M;
        u.a_idx = body ? ({2'b00, j} * 4'd3 + {2'b00, i})
                       : ({2'b00, i} * 4'd3 + {2'b00, j});
        u.b_src = bsrc;
        u.b_idx = j;
        u.mode  = WB_ROT;
        u.dst   = dst;
        u.didx  = {2'b00, i};
        u.clr   = (j == 2'd0);
        u.last  = (j == 2'd2);
        return u;
    endfunction

    // micro-op schedule of one integrate item
    function automatic uop_t sched(input logic [5:0] step);
        uop_t       u;
        logic [1:0] i;
        u = '0;
        i = 2'd0;
        priority if (step < 6'd9) begin
            u.mode = WB_QP;
            u.a_src = A_Q;
            u.b_src = B_Q;
            u.didx = step[3:0];
            u.clr = 1'b1;
            u.last = 1'b1;
            unique case (step[3:0])
                4'd0:    begin u.a_idx = QX; u.b_idx = QX[1:0]; end
                4'd1:    begin u.a_idx = QY; u.b_idx = QY[1:0]; end
                4'd2:    begin u.a_idx = QZ; u.b_idx = QZ[1:0]; end
                4'd3:    begin u.a_idx = QX; u.b_idx = QY[1:0]; end
                4'd4:    begin u.a_idx = QX; u.b_idx = QZ[1:0]; end
                4'd5:    begin u.a_idx = QY; u.b_idx = QZ[1:0]; end
                4'd6:    begin u.a_idx = QW; u.b_idx = QX[1:0]; end
                4'd7:    begin u.a_idx = QW; u.b_idx = QY[1:0]; end
                default: begin u.a_idx = QW; u.b_idx = QZ[1:0]; end
            endcase
        end else if (step == 6'd9) begin
            u.mode = WB_MAT;
            u.last = 1'b1;
        end else if (step < 6'd12) begin
            u.mode = WB_NONE;
        end else if (step < 6'd15) begin
            // only the z row of gravity is nonzero
            i = 2'(step - 6'd12);
            u.a_src = A_M;
            u.a_idx = 4'd6 + {2'b00, i};
            u.b_src = B_NEGG;
            u.mode = WB_ROT;
            u.dst = DST_GB;
            u.didx = {2'b00, i};
            u.clr = 1'b1;
            u.last = 1'b1;
        end else if (step < 6'd24) begin
            u = rot_uop(4'(step - 6'd15), 1'b1, B_VEL, DST_VB);
        end else if (step < 6'd33) begin
            u = rot_uop(4'(step - 6'd24), 1'b1, B_POS, DST_PB);
        end else if (step < 6'd36) begin
            i = 2'(step - 6'd33);
            u.a_src = A_LIN;
            u.a_idx = {2'b00, i};
            u.b_src = B_DT;
            u.mode = WB_VINT;
            u.didx = {2'b00, i};
            u.clr = 1'b1;
            u.last = 1'b1;
        end else if (step < 6'd39) begin
            i = 2'(step - 6'd36);
            u.a_src = A_VB;
            u.a_idx = {2'b00, i};
            u.b_src = B_DT;
            u.mode = WB_PINT;
            u.didx = {2'b00, i};
            u.clr = 1'b1;
            u.last = 1'b1;
        end else if (step < 6'd48) begin
            u = rot_uop(4'(step - 6'd39), 1'b0, B_VB, DST_VEL);
        end else begin
            u = rot_uop(4'(step - 6'd48), 1'b0, B_PB, DST_POS);
        end
        return u;
    endfunction

endpackage

FILE: sv/sins_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sins_ctrl
// Sequencer: accepts items, steps the micro-op schedule, hands off results.
// ----------------------------------------------------------------------------
module sins_ctrl
    import sins_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  logic      action,
    output logic      out_valid,
    input  logic      out_stall,
    output sins_cmd_t cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_RUN    = 2'd1;
    localparam logic [1:0] S_DRAIN  = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0] state_reg, state_next;
    logic [5:0] step_reg, step_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept;
    logic       out_free;

    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        step_next = step_reg;
        cmd = '0;
        cmd.capture = accept;
        cmd.restart = accept && action;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = action ? S_FINISH : S_RUN;
                    step_next = '0;
                end
            end
            S_RUN:
            begin
                cmd.uop = sched(step_reg);
                if (step_reg == LAST_STEP)
                begin
                    state_next = S_DRAIN;
                    step_next = '0;
                end
                else
                begin
                    step_next = step_reg + 6'd1;
                end
            end
            S_DRAIN:
            begin
                // let the last two pipeline stages write back
                step_next = step_reg + 6'd1;
                if (step_reg == 6'd1)
                    state_next = S_FINISH;
            end
            default:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: sv/sins_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sins_datapath
// Shared multiply-accumulate pipeline, operand and result registers, state.
// ----------------------------------------------------------------------------
module sins_datapath
    import sins_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  sins_cmd_t          cmd,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic signed [23:0] accel_x,
    input  logic signed [23:0] accel_y,
    input  logic signed [23:0] accel_z,
    input  logic signed [15:0] quat_w,
    input  logic signed [15:0] quat_x,
    input  logic signed [15:0] quat_y,
    input  logic signed [15:0] quat_z,
    input  logic [15:0]        time_step,
    output logic signed [31:0] vel_x,
    output logic signed [31:0] vel_y,
    output logic signed [31:0] vel_z,
    output logic signed [31:0] pos_x,
    output logic signed [31:0] pos_y,
    output logic signed [31:0] pos_z
);

    logic [22:0]        grav_reg;
    logic signed [31:0] vel0_reg [3];

    logic signed [15:0] q_reg [4];
    logic signed [23:0] a_reg [3];
    logic [15:0]        dt_reg;

    logic signed [31:0] qp_reg [9];
    logic signed [31:0] m_reg [9];
    logic signed [31:0] m_next [9];
    logic signed [31:0] gb_reg [3];
    logic signed [31:0] vb_reg [3];
    logic signed [31:0] pb_reg [3];
    logic signed [31:0] vel_reg [3];
    logic signed [31:0] pos_reg [3];
    logic signed [31:0] out_reg [6];

    uop_t               u1_reg, u2_reg;
    logic signed [32:0] op_a, op_b;
    logic signed [65:0] prod_full;
    logic signed [63:0] prod_reg;
    logic signed [63:0] acc_reg;
    logic signed [64:0] rot_sh, int_sh;
    logic signed [31:0] rot_res, vint_res, pint_res;
    logic [1:0]         d;
    logic               wb_en;

    // operand selection
    always_comb
    begin
        unique case (cmd.uop.a_src)
            A_Q:     op_a = 33'(q_reg[cmd.uop.a_idx[1:0]]);
            A_M:     op_a = 33'(m_reg[cmd.uop.a_idx]);
            A_LIN:   op_a = 33'(a_reg[cmd.uop.a_idx[1:0]]) - 33'(gb_reg[cmd.uop.a_idx[1:0]]);
            default: op_a = 33'(vb_reg[cmd.uop.a_idx[1:0]]);
        endcase
        unique case (cmd.uop.b_src)
            B_Q:     op_b = 33'(q_reg[cmd.uop.b_idx]);
            B_NEGG:  op_b = 33'sd0 - $signed({10'd0, grav_reg});
            B_VEL:   op_b = 33'(vel_reg[cmd.uop.b_idx]);
            B_POS:   op_b = 33'(pos_reg[cmd.uop.b_idx]);
            B_VB:    op_b = 33'(vb_reg[cmd.uop.b_idx]);
            B_PB:    op_b = 33'(pb_reg[cmd.uop.b_idx]);
            default: op_b = $signed({17'd0, dt_reg});
        endcase
    end

    assign prod_full = op_a * op_b;

    // rotation matrix from the quaternion products xx yy zz xy xz yz wx wy wz
    always_comb
    begin
        m_next[0] = mat_diag(qp_reg[1], qp_reg[2]);
        m_next[1] = mat_off(qp_reg[3], qp_reg[8], 1'b1);
        m_next[2] = mat_off(qp_reg[4], qp_reg[7], 1'b0);
        m_next[3] = mat_off(qp_reg[3], qp_reg[8], 1'b0);
        m_next[4] = mat_diag(qp_reg[0], qp_reg[2]);
        m_next[5] = mat_off(qp_reg[5], qp_reg[6], 1'b1);
        m_next[6] = mat_off(qp_reg[4], qp_reg[7], 1'b1);
        m_next[7] = mat_off(qp_reg[5], qp_reg[6], 1'b0);
        m_next[8] = mat_diag(qp_reg[0], qp_reg[1]);
    end

    // writeback arithmetic: round half up, then saturate
    assign d        = u2_reg.didx[1:0];
    assign rot_sh   = (65'(acc_reg) + 65'sd134217728) >>> 28;
    assign int_sh   = (65'(acc_reg) + 65'sd524288) >>> 20;
    assign rot_res  = sat32(rot_sh);
    assign vint_res = sat32(65'(vb_reg[d]) + int_sh);
    assign pint_res = sat32(65'(pb_reg[d]) + int_sh);
    assign wb_en    = u2_reg.last && (u2_reg.mode != WB_NONE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            u1_reg <= '0;
            u2_reg <= '0;
            grav_reg <= GRAV_RESET[22:0];
            for (int k = 0; k < 3; k++)
            begin
                vel0_reg[k] <= '0;
                vel_reg[k] <= '0;
                pos_reg[k] <= '0;
            end
        end
        else
        begin
            u1_reg <= cmd.uop;
            u2_reg <= u1_reg;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_GRAV:   grav_reg <= cfg_data[22:0];
                    CFG_VEL0_X: vel0_reg[0] <= cfg_data;
                    CFG_VEL0_Y: vel0_reg[1] <= cfg_data;
                    default:    vel0_reg[2] <= cfg_data;
                endcase
            end
            if (cmd.restart)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    vel_reg[k] <= vel0_reg[k];
                    pos_reg[k] <= '0;
                end
            end
            else if (wb_en && u2_reg.mode == WB_ROT && u2_reg.dst == DST_VEL)
            begin
                vel_reg[d] <= rot_res;
            end
            else if (wb_en && u2_reg.mode == WB_ROT && u2_reg.dst == DST_POS)
            begin
                pos_reg[d] <= rot_res;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            q_reg[0] <= quat_w;
            q_reg[1] <= quat_x;
            q_reg[2] <= quat_y;
            q_reg[3] <= quat_z;
            a_reg[0] <= accel_x;
            a_reg[1] <= accel_y;
            a_reg[2] <= accel_z;
            dt_reg <= time_step;
        end
        prod_reg <= $signed(prod_full[63:0]);
        if (u1_reg.mode != WB_NONE)
            acc_reg <= (u1_reg.clr ? 64'sd0 : acc_reg) + prod_reg;
        if (wb_en)
        begin
            unique case (u2_reg.mode)
                WB_QP:   qp_reg[u2_reg.didx] <= acc_reg[31:0];
                WB_MAT:
                begin
                    for (int k = 0; k < 9; k++)
                        m_reg[k] <= m_next[k];
                end
                WB_ROT:
                begin
                    unique case (u2_reg.dst)
                        DST_GB:  gb_reg[d] <= rot_res;
                        DST_VB:  vb_reg[d] <= rot_res;
                        DST_PB:  pb_reg[d] <= rot_res;
                        default: ;
                    endcase
                end
                WB_VINT: vb_reg[d] <= vint_res;
                WB_PINT: pb_reg[d] <= pint_res;
                default: ;
            endcase
        end
        if (cmd.out_load)
        begin
            for (int k = 0; k < 3; k++)
            begin
                out_reg[k] <= vel_reg[k];
                out_reg[3 + k] <= pos_reg[k];
            end
        end
    end

    assign vel_x = out_reg[0];
    assign vel_y = out_reg[1];
    assign vel_z = out_reg[2];
    assign pos_x = out_reg[3];
    assign pos_y = out_reg[4];
    assign pos_z = out_reg[5];

endmodule

FILE: sv/strapdown_ins_integrator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strapdown_ins_integrator
// Quaternion strapdown integrator: velocity and position in the ground frame.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): one item per update, action 0 integrates
// with the given acceleration, quaternion and time step, action 1 restarts
// (velocity from the init_vel registers, position zero).
// Output channel (out_valid / out_stall): one item per input item carrying
// the new ground velocity and position.
// Config channel (cfg_valid / cfg_ready): cfg_ready is always high; write only
// while no item is in flight.
// An integrate item raises out_valid after 57 micro-ops issued to one shared
// 33x33 multiplier (quaternion products, matrix build, three body rotations,
// integration, two ground rotations), the pipeline drain and the output load.
// A restart goes straight to the output load. The next item can be accepted
// in the same cycle that out_valid rises. One item is worked on at a time; a
// new item is accepted while a finished one waits in the output register, but
// its result is held back until that register is taken.
// Reset clears velocity, position and the initial velocity, sets gravity to
// its default and empties the output register.
// ----------------------------------------------------------------------------
module strapdown_ins_integrator
    import sins_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               action,
    input  logic signed [23:0] accel_x,
    input  logic signed [23:0] accel_y,
    input  logic signed [23:0] accel_z,
    input  logic signed [15:0] quat_w,
    input  logic signed [15:0] quat_x,
    input  logic signed [15:0] quat_y,
    input  logic signed [15:0] quat_z,
    input  logic [15:0]        time_step,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] vel_x,
    output logic signed [31:0] vel_y,
    output logic signed [31:0] vel_z,
    output logic signed [31:0] pos_x,
    output logic signed [31:0] pos_y,
    output logic signed [31:0] pos_z,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    sins_cmd_t cmd;

    assign cfg_ready = 1'b1;

    sins_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    sins_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accel_x   (accel_x),
        .accel_y   (accel_y),
        .accel_z   (accel_z),
        .quat_w    (quat_w),
        .quat_x    (quat_x),
        .quat_y    (quat_y),
        .quat_z    (quat_z),
        .time_step (time_step),
        .vel_x     (vel_x),
        .vel_y     (vel_y),
        .vel_z     (vel_z),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .pos_z     (pos_z)
    );

endmodule
